@@ hdl/grb_pkg.sv @@
// Package for the group reverse buffer: payload types of the three channels,
// the descriptor of a closed group that passes from front to back, and widths.
// Used by every other file of the block but grb_chan_if and grb_ram; depends on nothing.
package grb_pkg;

   localparam int VALUE_W       = 32;
   localparam int GROUP_SIZE_W  = 7;
   // Wide enough for a group count at the largest supported maximum group (1024).
   localparam int GROUP_COUNT_W = 11;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      array_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_res;
      logic                      group_last;
      logic                      array_last;
   } rsp_payload_type;

   typedef logic [GROUP_SIZE_W-1:0] csr_payload_type;

   localparam csr_payload_type GROUP_SIZE_RESET = csr_payload_type'(1);

   typedef struct packed {
      logic                     bank;
      logic [GROUP_COUNT_W-1:0] count;
      logic                     array_end;
   } group_desc_type;

endpackage

@@ hdl/grb_chan_if.sv @@
// Valid/ready channel used for the request, response and register ports.
// The payload type is a parameter; the types come from grb_pkg.
interface grb_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/grb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module grb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/grb_front.sv @@
// Front end: takes request beats and register writes, writes each element into
// the filling bank and closes a group into the queue. Uses grb_pkg, grb_chan_if.
module grb_front #(
   parameter int MAX_GROUP = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   grb_chan_if.sink                       req_ch,
   grb_chan_if.sink                       csr_ch,
   input  logic                           queue_full,
   output logic                           queue_push,
   output grb_pkg::group_desc_type        queue_desc,
   output logic                           wr_en,
   output logic [(MAX_GROUP > 1 ? $clog2(MAX_GROUP) : 1):0] wr_addr,
   output logic [grb_pkg::VALUE_W-1:0]    wr_data
);
   localparam int CW = $clog2(MAX_GROUP + 1);
   localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int EW = (CW > grb_pkg::GROUP_SIZE_W) ? CW : grb_pkg::GROUP_SIZE_W;

   logic [CW-1:0]            fill_ff, fill_in;
   logic                     bank_ff, bank_in;
   grb_pkg::csr_payload_type size_ff, size_in;

   logic [CW-1:0] fill_next;
   logic [EW-1:0] eff_size;
   logic          accept;
   logic          close;

   assign req_ch.ready = !queue_full;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;

   // A size of zero acts as one; sizes above the bank depth saturate.
   always_comb begin
      priority if (size_ff == '0) begin
         eff_size = EW'(1);
      end else if (EW'(size_ff) > EW'(MAX_GROUP)) begin
         eff_size = EW'(MAX_GROUP);
      end else begin
         eff_size = EW'(size_ff);
      end
   end

   assign fill_next = fill_ff + CW'(1);
   assign close     = req_ch.payload.array_end || (EW'(fill_next) >= eff_size);

   assign wr_en   = accept;
   assign wr_addr = {bank_ff, fill_ff[IW-1:0]};
   assign wr_data = req_ch.payload.value;

   assign queue_push = accept && close;
   always_comb begin
      queue_desc           = '0;
      queue_desc.bank      = bank_ff;
      queue_desc.count     = grb_pkg::GROUP_COUNT_W'(fill_next);
      queue_desc.array_end = req_ch.payload.array_end;
   end

   always_comb begin
      fill_in = fill_ff;
      bank_in = bank_ff;
      size_in = size_ff;
      if (accept) begin
         if (close) begin
            fill_in = '0;
            bank_in = !bank_ff;
         end else begin
            fill_in = fill_next;
         end
      end
      if (csr_ch.valid) begin
         size_in = csr_ch.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= 1'b0;
         size_ff <= grb_pkg::GROUP_SIZE_RESET;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         size_ff <= size_in;
      end
   end

   // A group always closes before it would overrun its bank.
   a_fill_in_bank: assert property (@(posedge clock) disable iff (reset)
      fill_ff < CW'(MAX_GROUP))
      else $error("fill count reached the bank depth");
endmodule

@@ hdl/grb_group_queue.sv @@
// Two-entry queue of closed-group descriptors between front and back. An entry
// stays until its group has been read out, so it also tracks bank ownership.
// Uses grb_pkg.
module grb_group_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  grb_pkg::group_desc_type push_desc,
   input  logic                    pop,
   output logic                    head_valid,
   output grb_pkg::group_desc_type head_desc,
   output logic                    full
);
   grb_pkg::group_desc_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head_valid = cnt_ff != 2'd0;
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign full       = cnt_ff == 2'd2;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("group queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("group queue underflow");
endmodule

@@ hdl/grb_back.sv @@
// Back end: reads the group at the queue head from the RAM, last element first,
// and delivers beats through a two-entry output buffer. Uses grb_pkg, grb_chan_if.
module grb_back #(
   parameter int MAX_GROUP = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  grb_pkg::group_desc_type        head_desc,
   output logic                           queue_pop,
   output logic                           rd_en,
   output logic [(MAX_GROUP > 1 ? $clog2(MAX_GROUP) : 1):0] rd_addr,
   input  logic [grb_pkg::VALUE_W-1:0]    rd_data,
   grb_chan_if.source                     rsp_ch
);
   localparam int CW = $clog2(MAX_GROUP + 1);
   localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

   logic [CW-1:0] pos_ff, pos_in;
   logic          pend_ff;
   logic          meta_group_last_ff, meta_array_last_ff;
   grb_pkg::rsp_payload_type buf_ff [2];
   logic          buf_wr_ff, buf_wr_in;
   logic          buf_rd_ff, buf_rd_in;
   logic [1:0]    occ_ff, occ_in;

   logic [CW-1:0] count;
   logic          final_elem;
   logic          pop_out;
   logic [2:0]    load;
   logic          issue;
   grb_pkg::rsp_payload_type entry;

   assign count      = head_desc.count[CW-1:0];
   assign final_elem = (pos_ff + CW'(1)) == count;
   assign pop_out    = rsp_ch.valid && rsp_ch.ready;

   // Beats in the buffer plus the read in flight must leave room for this read.
   assign load  = {1'b0, occ_ff} + {2'b00, pend_ff};
   assign issue = head_valid && ((load <= 3'd1) || ((load == 3'd2) && pop_out));

   assign rd_en     = issue;
   assign rd_addr   = {head_desc.bank, IW'(count - pos_ff - CW'(1))};
   assign queue_pop = issue && final_elem;

   always_comb begin
      entry            = '0;
      entry.value_res  = $signed(rd_data);
      entry.group_last = meta_group_last_ff;
      entry.array_last = meta_array_last_ff;
   end

   assign rsp_ch.valid   = occ_ff != 2'd0;
   assign rsp_ch.payload = buf_ff[buf_rd_ff];

   always_comb begin
      pos_in    = pos_ff;
      if (issue) begin
         pos_in = final_elem ? '0 : pos_ff + CW'(1);
      end
      buf_wr_in = pend_ff ? !buf_wr_ff : buf_wr_ff;
      buf_rd_in = pop_out ? !buf_rd_ff : buf_rd_ff;
      occ_in    = occ_ff + {1'b0, pend_ff} - {1'b0, pop_out};
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         meta_group_last_ff <= final_elem;
         meta_array_last_ff <= final_elem && head_desc.array_end;
      end
      if (pend_ff) begin
         buf_ff[buf_wr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         pend_ff   <= 1'b0;
         buf_wr_ff <= 1'b0;
         buf_rd_ff <= 1'b0;
         occ_ff    <= 2'd0;
      end else begin
         pos_ff    <= pos_in;
         pend_ff   <= issue;
         buf_wr_ff <= buf_wr_in;
         buf_rd_ff <= buf_rd_in;
         occ_ff    <= occ_in;
      end
   end

   a_buffer_room: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, occ_ff} + {2'b00, pend_ff}) <= 3'd2)
      else $error("output buffer overcommitted");

   a_pos_in_group: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (pos_ff < count))
      else $error("read position beyond the group");
endmodule

@@ hdl/group_reverse_buffer.sv @@
// Top level of the group reverse buffer: front end, group queue, ping-pong RAM
// and back end. Uses grb_pkg, grb_chan_if, grb_ram, grb_front, grb_group_queue, grb_back.
//
//   channel  direction  payload                              beat on
//   req_ch   in         value, array_end                     valid && ready
//   rsp_ch   out        value_res, group_last, array_last    valid && ready
//   csr_ch   in         group_size (7 bits)                  valid && ready
//
// Sustained rate is one beat per cycle on each side while rsp_ch is ready, set by the
// single write and single read port of the two-bank group RAM. A group's first beat
// leaves through the group queue, the RAM read register and the output buffer.
// req_ch stalls only while both banks hold closed groups that are not yet read out.
// Synchronous reset clears the counters, the queue and the buffer; group_size returns to 1.
module group_reverse_buffer #(
   parameter int MAX_GROUP = 64
) (
   input  logic       clock,
   input  logic       reset,
   grb_chan_if.sink   req_ch,
   grb_chan_if.source rsp_ch,
   grb_chan_if.sink   csr_ch
);
   localparam int IW    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int DEPTH = 2 ** (IW + 1);

   logic                        queue_full;
   logic                        queue_push;
   logic                        queue_pop;
   logic                        head_valid;
   grb_pkg::group_desc_type     push_desc;
   grb_pkg::group_desc_type     head_desc;
   logic                        wr_en;
   logic [IW:0]                 wr_addr;
   logic [grb_pkg::VALUE_W-1:0] wr_data;
   logic                        rd_en;
   logic [IW:0]                 rd_addr;
   logic [grb_pkg::VALUE_W-1:0] rd_data;

   grb_front #(.MAX_GROUP(MAX_GROUP)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_desc (push_desc),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   grb_group_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_desc  (push_desc),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .full       (queue_full)
   );

   grb_ram #(.WIDTH(grb_pkg::VALUE_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   grb_back #(.MAX_GROUP(MAX_GROUP)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .queue_pop  (queue_pop),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_ch     (rsp_ch)
   );
endmodule

@@ tb/grb_checker.sv @@
// Checker for the group reverse buffer: watches the request, response and register
// channels, predicts every reversed group and compares each response beat with it.
// Depends on grb_pkg for the payload types and widths.
module grb_checker #(
   parameter int MAX_GROUP = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  grb_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  grb_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  grb_pkg::csr_payload_type csr_payload,
   output int unsigned              outstanding,
   output int unsigned              fail_count
);

   logic signed [grb_pkg::VALUE_W-1:0] held_values [MAX_GROUP];
   int unsigned                        held_count;
   grb_pkg::csr_payload_type           group_size_reg;
   grb_pkg::rsp_payload_type           reversed_q [$];

   // A size of zero behaves as one and anything above the store depth saturates.
   function automatic int unsigned closing_size(grb_pkg::csr_payload_type size);
      int unsigned s;
      s = size;
      if (s == 0) s = 1;
      if (s > MAX_GROUP) s = MAX_GROUP;
      return s;
   endfunction

   task automatic record_failure(string what, grb_pkg::rsp_payload_type want,
                                 grb_pkg::rsp_payload_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%s: expected value %0d group_last %0b array_last %0b, %s %0d %s %0b %s %0b",
                  what, want.value_res, want.group_last, want.array_last,
                  "got value", got.value_res, "group_last", got.group_last,
                  "array_last", got.array_last);
   endtask

   task automatic take_element(grb_pkg::req_payload_type elem);
      grb_pkg::rsp_payload_type beat;
      int unsigned              n;
      if (held_count >= MAX_GROUP) held_count = 0;
      held_values[held_count] = elem.value;
      held_count++;
      if (held_count >= closing_size(group_size_reg) || elem.array_end) begin
         n = held_count;
         for (int unsigned k = 0; k < n; k++) begin
            beat.value_res  = held_values[n - 1 - k];
            beat.group_last = (k + 1 == n);
            beat.array_last = (k + 1 == n) && elem.array_end;
            reversed_q.push_back(beat);
         end
         held_count = 0;
      end
   endtask

   task automatic check_beat(grb_pkg::rsp_payload_type got);
      grb_pkg::rsp_payload_type want;
      if (reversed_q.size() == 0) begin
         want = '0;
         record_failure("unexpected response beat", want, got);
      end else begin
         want = reversed_q.pop_front();
         if (got.value_res !== want.value_res || got.group_last !== want.group_last ||
             got.array_last !== want.array_last)
            record_failure("response mismatch", want, got);
      end
   endtask

   // A register write takes effect after its edge, so a request beat at the same edge
   // still sees the old size.
   always @(posedge clock) begin
      if (reset) begin
         held_count     = 0;
         group_size_reg = grb_pkg::GROUP_SIZE_RESET;
         reversed_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_beat(rsp_payload);
         if (req_valid && req_ready) take_element(req_payload);
         if (csr_valid && csr_ready) group_size_reg = csr_payload;
      end
      outstanding <= reversed_q.size();
   end

endmodule

@@ tb/tb_group_reverse_buffer.sv @@
// Testbench top for the group reverse buffer: clock, reset, request and register
// stimulus, response back-pressure, watchdog and verdict.
// Depends on grb_pkg, grb_chan_if, group_reverse_buffer and grb_checker.
module tb_group_reverse_buffer;

   localparam int          MAX_GROUP       = 64;
   localparam int unsigned RANDOM_ELEMENTS = 200;
   localparam int unsigned LATE_ELEMENTS   = 155;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;

   logic        clock;
   logic        reset;
   bit          late_run;
   bit          req_gaps_on;
   int unsigned random_sent;
   int unsigned quiet_cycles;
   int unsigned outstanding;
   int unsigned fail_count;

   grb_chan_if #(.payload_type(grb_pkg::req_payload_type)) req_ch ();
   grb_chan_if #(.payload_type(grb_pkg::rsp_payload_type)) rsp_ch ();
   grb_chan_if #(.payload_type(grb_pkg::csr_payload_type)) csr_ch ();

   group_reverse_buffer #(.MAX_GROUP(MAX_GROUP)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   grb_checker #(.MAX_GROUP(MAX_GROUP)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_payload (req_ch.payload),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_ch.payload),
      .csr_valid   (csr_ch.valid),
      .csr_ready   (csr_ch.ready),
      .csr_payload (csr_ch.payload),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Response back-pressure: runs of readiness, some long, broken by stall bursts.
   initial begin
      rsp_ch.ready <= 1'b1;
      forever begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(60, 150)) @(posedge clock);
         else
            repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!late_run && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [grb_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Valid stays high from one beat to the next unless a gap is inserted.
   task automatic send_element(logic signed [grb_pkg::VALUE_W-1:0] value, logic array_end);
      if (req_gaps_on && !late_run && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.payload.value     <= value;
      req_ch.payload.array_end <= array_end;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_array(int unsigned len, bit closes);
      for (int unsigned i = 0; i < len; i++) begin
         send_element(pick_value(), closes && (i + 1 == len));
         random_sent++;
         if (random_sent >= LATE_ELEMENTS) late_run = 1'b1;
      end
   endtask

   // The response count seen here is registered in the checker, so it is trusted only
   // from the next edge on. A partly filled group gives no response, so a settling wait
   // of SETTLE_CYCLES follows the drain.
   task automatic write_group_size(grb_pkg::csr_payload_type size);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= size;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      grb_pkg::csr_payload_type size;
      int unsigned              span;
      int unsigned              arrays;
      int unsigned              len;
      bit                       leave_open;

      late_run       = 1'b0;
      req_gaps_on    = 1'b1;
      random_sent    = 0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.payload <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset value of the size: every element comes straight back.
      send_element(32'sh7FFF_FFFF, 1'b0);
      send_element(32'sh8000_0000, 1'b1);

      // A size of zero behaves as one.
      write_group_size(grb_pkg::csr_payload_type'(0));
      send_element(-32'sd1, 1'b0);
      send_element('0, 1'b1);

      // One full group of four, then the array ends after a single element.
      write_group_size(grb_pkg::csr_payload_type'(4));
      send_element(32'sd1, 1'b0);
      send_element(-32'sd1, 1'b0);
      send_element(32'sh8000_0000, 1'b0);
      send_element(32'sh7FFF_FFFF, 1'b0);
      send_element(32'sh5555_5555, 1'b1);

      // The size drops to two with three elements held: the next one flushes all four.
      send_element(32'shAAAA_AAAA, 1'b0);
      send_element(32'sh0F0F_0F0F, 1'b0);
      send_element(32'shF0F0_F0F0, 1'b0);
      write_group_size(grb_pkg::csr_payload_type'(2));
      send_element(32'sh1234_5678, 1'b0);
      send_element(32'shFEDC_BA98, 1'b1);

      // The largest register value saturates to the store depth.
      write_group_size(grb_pkg::csr_payload_type'(127));
      send_array(MAX_GROUP + 2, 1'b1);
      write_group_size(grb_pkg::csr_payload_type'(MAX_GROUP));
      send_array(MAX_GROUP, 1'b1);

      while (random_sent < RANDOM_ELEMENTS) begin
         req_gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 11))
            0:       size = grb_pkg::csr_payload_type'($urandom_range(33, 127));
            1:       size = grb_pkg::csr_payload_type'(0);
            2:       size = grb_pkg::csr_payload_type'($urandom_range(9, 20));
            default: size = grb_pkg::csr_payload_type'($urandom_range(1, 8));
         endcase
         span = (size == 0) ? 1 : (size > MAX_GROUP) ? MAX_GROUP : size;
         write_group_size(size);
         arrays     = (span > 8) ? 1 : $urandom_range(1, 3);
         leave_open = ($urandom_range(0, 4) == 0);
         for (int unsigned a = 0; a < arrays; a++) begin
            len = $urandom_range(1, (span > 8) ? span + 4 : 3 * span + 1);
            send_array(len, !(leave_open && a + 1 == arrays));
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
